@@ hw/rtl/energy_detect_listen_before_talk_macros.svh @@
// Assertion macros shared by the energy detect RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ENERGY_DETECT_LISTEN_BEFORE_TALK_MACROS_SVH
`define ENERGY_DETECT_LISTEN_BEFORE_TALK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EDLBT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define EDLBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/edlbt_pkg.sv @@
`default_nettype none
package edlbt_pkg;

	// Ring depth default
	localparam int WINDOW_DEF = 512;

	// Fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int POWER_W    = 32;
	localparam int SUM_W      = 41;
	localparam int FILL_OUT_W = 10;
	localparam int THR_W      = 32;
	localparam int LEN_W      = 16;
	localparam int MINFILL_W  = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register reset values
	localparam logic [THR_W-1:0]     THR_RESET     = 32'd7;
	localparam logic [LEN_W-1:0]     LEN_RESET     = 16'd384;
	localparam logic [MINFILL_W-1:0] MINFILL_RESET = 10'd100;

	// Register indexes on the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_SENSE_LEN = 2'd1,
		REG_MIN_FILL  = 2'd2
	} cfg_reg_t;

	// Input word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_i;
		logic signed [SAMPLE_W-1:0] sample_q;
		logic                       start_sense;
	} sample_t;

	// Result word
	typedef struct packed {
		logic [SUM_W-1:0]      window_power_sum;
		logic [FILL_OUT_W-1:0] window_fill;
		logic                  busy_now;
		logic                  verdict_valid;
		logic                  link_free;
	} result_t;

	// Control into the sensing sequencer
	typedef struct packed {
		logic step;
		logic start;
		logic busy;
	} sense_ctl_t;

	// Verdict out of the sensing sequencer
	typedef struct packed {
		logic done;
		logic free;
	} verdict_t;

endpackage
`default_nettype wire

@@ hw/rtl/edlbt_ram.sv @@
`default_nettype none
module edlbt_ram #(
	parameter int WIDTH = edlbt_pkg::POWER_W,
	parameter int DEPTH = edlbt_pkg::WINDOW_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/edlbt_sense.sv @@
`default_nettype none
module edlbt_sense (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire edlbt_pkg::sense_ctl_t         ctl,
	input  wire logic [edlbt_pkg::LEN_W-1:0]   sense_len,
	output edlbt_pkg::verdict_t                verdict
);

	typedef enum logic {
		SENSE_IDLE,
		SENSE_RUN
	} sense_state_t;

	sense_state_t                  state_q;
	sense_state_t                  state_d;
	logic [edlbt_pkg::LEN_W-1:0]   elapsed_q;
	logic [edlbt_pkg::LEN_W-1:0]   elapsed_d;
	logic [edlbt_pkg::LEN_W-1:0]   len_eff;
	logic                          running;

	// Zero length counts as one sample
	assign len_eff = (sense_len == '0) ? edlbt_pkg::LEN_W'(1) : sense_len;

	// Start restarts the period with this word
	always_comb begin
		running   = ctl.start || (state_q == SENSE_RUN);
		elapsed_d = ctl.start ? '0 : elapsed_q;
		state_d   = running ? SENSE_RUN : SENSE_IDLE;
		verdict   = '0;
		if (running) begin
			elapsed_d = elapsed_d + 1'b1;
			if (ctl.busy) begin
				verdict.done = 1'b1;
				state_d      = SENSE_IDLE;
			end else if (elapsed_d >= len_eff) begin
				verdict.done = 1'b1;
				verdict.free = 1'b1;
				state_d      = SENSE_IDLE;
			end
		end
	end

	// Advance on each word that leaves for the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SENSE_IDLE;
			elapsed_q <= '0;
		end else if (ctl.step) begin
			state_q   <= state_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/energy_detect_listen_before_talk.sv @@
`default_nettype none
// Channel  Signals                              Payload
// sample   sample_valid / sample_stall          edlbt_pkg::sample_t
// result   result_valid / result_stall          edlbt_pkg::result_t
// cfg      cfg_valid / cfg_ready                cfg_index, cfg_data
//
// One sample word in per cycle unless stalled; it passes stage 1, then the result register.
// Stage 1 holds the sample power, the oldest ring entry and the threshold product.
// The result register takes the running sum, the busy compare and the verdict.
// The ring memory takes one read at acceptance and one write as a word leaves stage 1.
// Reset clears control and the running sum; the ring needs no clearing pass.
// A stalled result holds stage 1; with both full the input stalls. cfg_ready is always high.
`include "energy_detect_listen_before_talk_macros.svh"
module energy_detect_listen_before_talk #(
	parameter int WINDOW = edlbt_pkg::WINDOW_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 sample_valid,
	output logic                                      sample_stall,
	input  wire edlbt_pkg::sample_t                   sample,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output edlbt_pkg::result_t                        result,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [edlbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [edlbt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int PROD_W = edlbt_pkg::THR_W + FILL_W;
	localparam int CMP_W  = (PROD_W > edlbt_pkg::SUM_W) ? PROD_W : edlbt_pkg::SUM_W;
	localparam int MF_W   = (FILL_W > edlbt_pkg::MINFILL_W) ? FILL_W : edlbt_pkg::MINFILL_W;

	// Config registers
	logic [edlbt_pkg::THR_W-1:0]     thr_q;
	logic [edlbt_pkg::LEN_W-1:0]     sense_len_q;
	logic [edlbt_pkg::MINFILL_W-1:0] min_fill_q;

	// Front-end state
	logic [PTR_W-1:0]  wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [edlbt_pkg::SUM_W-1:0] sum_q;

	// Stage 1
	logic                          v_s1;
	logic [edlbt_pkg::POWER_W-1:0] power_s1;
	logic [PTR_W-1:0]              wp_s1;
	logic [FILL_W-1:0]             fill_s1;
	logic                          full_s1;
	logic                          start_s1;
	logic [PROD_W-1:0]             prod_s1;

	// Handshake and datapath nets
	logic                          accept;
	logic                          out_free;
	logic                          s1_free;
	logic                          s1_adv;
	logic signed [edlbt_pkg::POWER_W-1:0] sq_i;
	logic signed [edlbt_pkg::POWER_W-1:0] sq_q;
	logic [edlbt_pkg::POWER_W-1:0] power;
	logic [edlbt_pkg::POWER_W-1:0] oldest;
	logic [FILL_W-1:0]             fill_next;
	logic [edlbt_pkg::SUM_W-1:0]   sum_next;
	logic                          busy;
	edlbt_pkg::sense_ctl_t         sense_ctl;
	edlbt_pkg::verdict_t           verdict;

	assign cfg_ready = 1'b1;

	// Take config writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= edlbt_pkg::THR_RESET;
			sense_len_q <= edlbt_pkg::LEN_RESET;
			min_fill_q  <= edlbt_pkg::MINFILL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (edlbt_pkg::cfg_reg_t'(cfg_index))
				edlbt_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				edlbt_pkg::REG_SENSE_LEN: sense_len_q <= cfg_data[edlbt_pkg::LEN_W-1:0];
				edlbt_pkg::REG_MIN_FILL:  min_fill_q <= cfg_data[edlbt_pkg::MINFILL_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage flow: stage 1 moves when the result register is free
	assign out_free     = !result_valid || !result_stall;
	assign s1_adv       = v_s1 && out_free;
	assign s1_free      = !v_s1 || out_free;
	assign sample_stall = !s1_free;
	assign accept       = sample_valid && !sample_stall;

	// Sample power
	assign sq_i  = $signed(sample.sample_i) * $signed(sample.sample_i);
	assign sq_q  = $signed(sample.sample_q) * $signed(sample.sample_q);
	assign power = $unsigned(sq_i) + $unsigned(sq_q);

	// Fill after this word
	assign fill_next = (fill_q == FILL_W'(WINDOW)) ? fill_q : fill_q + 1'b1;

	// Ring of powers; read the oldest entry as a word enters stage 1
	edlbt_ram #(
		.WIDTH(edlbt_pkg::POWER_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(wp_s1),
		.wdata(power_s1),
		.re   (accept),
		.raddr(wp_q),
		.rdata(oldest)
	);

	// Advance pointer and fill on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (accept) begin
				wp_q <= (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
				fill_q <= fill_next;
			end
			if (s1_free) begin
				v_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			power_s1 <= power;
			wp_s1    <= wp_q;
			full_s1  <= (fill_q == FILL_W'(WINDOW));
			fill_s1  <= fill_next;
			start_s1 <= sample.start_sense;
			prod_s1  <= PROD_W'(thr_q) * PROD_W'(fill_next);
		end
	end

	// Drop the oldest power once the ring is full, add the new one
	assign sum_next = sum_q - (full_s1 ? edlbt_pkg::SUM_W'(oldest) : '0)
		+ edlbt_pkg::SUM_W'(power_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (s1_adv) begin
			sum_q <= sum_next;
		end
	end

	// Busy: enough fill and mean power at threshold
	assign busy = (MF_W'(fill_s1) >= MF_W'(min_fill_q))
		&& (CMP_W'(sum_next) >= CMP_W'(prod_s1));

	assign sense_ctl.step  = s1_adv;
	assign sense_ctl.start = start_s1;
	assign sense_ctl.busy  = busy;

	edlbt_sense u_sense (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sense_ctl),
		.sense_len(sense_len_q),
		.verdict  (verdict)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= s1_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result.window_power_sum <= sum_next;
			result.window_fill      <= edlbt_pkg::FILL_OUT_W'(fill_s1);
			result.busy_now         <= busy;
			result.verdict_valid    <= verdict.done;
			result.link_free        <= verdict.free;
		end
	end

	`EDLBT_ASSERT_NEXT(a_accept_enters_s1, accept, v_s1, "accepted word missing in stage 1")
	`EDLBT_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(WINDOW), "fill beyond window")
	`EDLBT_ASSERT_NOW(a_ptr_bound, 1'b1, wp_q <= PTR_W'(WINDOW - 1), "pointer beyond ring")
	`EDLBT_ASSERT_NOW(a_free_not_busy, result_valid && result.link_free,
		result.verdict_valid && !result.busy_now, "free verdict on busy window")

endmodule
`default_nettype wire
